FILE: hdl/fsg_pkg.sv
`timescale 1ns / 1ps

package fsg_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 64;
    localparam int PAYLOAD_BITS = 8;

    localparam int CELL_COUNT   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS    = $clog2(CELL_COUNT);
    localparam int X_BITS       = $clog2(MAX_WIDTH);
    localparam int Y_BITS       = $clog2(MAX_HEIGHT);

    localparam int CMD_BITS     = 2;
    localparam int COORD_BITS   = 6;
    localparam int PAY_IO_BITS  = 8;
    localparam int CFG_BITS     = 7;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_BITS-1:0] CFG_WIDTH_RESET  = 7'd64;
    localparam logic [CFG_BITS-1:0] CFG_HEIGHT_RESET = 7'd64;

    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_PUSH,
        ST_S_HERE,
        ST_S_HC,
        ST_S_B,
        ST_S_BR,
        ST_S_R,
        ST_S_BL,
        ST_S_L,
        ST_S_MOVE,
        ST_S_VAC
    } t_state;

    typedef struct packed {
        logic                    occ;
        logic [PAYLOAD_BITS-1:0] pay;
    } t_cell;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        t_cell                wdata;
    } t_ram_req;

    typedef struct packed {
        logic [CFG_BITS-1:0] w;
        logic [CFG_BITS-1:0] h;
    } t_grid;

    function automatic logic [ADDR_BITS-1:0] slot(
        input logic [X_BITS-1:0] x,
        input logic [Y_BITS-1:0] y
    );
        return ADDR_BITS'(y) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(x);
    endfunction

endpackage

FILE: hdl/fsg_if.sv
`timescale 1ns / 1ps

interface fsg_in_if;
    logic                            valid;
    logic                            ready;
    logic [fsg_pkg::CMD_BITS-1:0]    cmd;
    logic [fsg_pkg::COORD_BITS-1:0]  cell_x;
    logic [fsg_pkg::COORD_BITS-1:0]  cell_y;
    logic                            occupied_in;
    logic [fsg_pkg::PAY_IO_BITS-1:0] payload_in;

    modport source (output valid, cmd, cell_x, cell_y, occupied_in, payload_in, input ready);
    modport sink   (input valid, cmd, cell_x, cell_y, occupied_in, payload_in, output ready);
endinterface

interface fsg_out_if;
    logic                            valid;
    logic                            ready;
    logic                            occupied_out;
    logic [fsg_pkg::PAY_IO_BITS-1:0] payload_out;
    logic                            in_range;

    modport source (output valid, occupied_out, payload_out, in_range, input ready);
    modport sink   (input valid, occupied_out, payload_out, in_range, output ready);
endinterface

interface fsg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fsg_pkg::CFG_IDX_BITS-1:0] index;
    logic [fsg_pkg::CFG_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/fsg_ram.sv
`timescale 1ns / 1ps

module fsg_ram (
    input  logic              i_clk,
    input  fsg_pkg::t_ram_req i_req,
    output fsg_pkg::t_cell    o_rdata
);
    import fsg_pkg::*;

    t_cell r_mem [CELL_COUNT];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fsg_seq.sv
`timescale 1ns / 1ps

module fsg_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsg_pkg::t_grid    i_grid,
    fsg_in_if.sink            i_req,
    fsg_out_if.source         o_res,
    output fsg_pkg::t_ram_req o_ram_req,
    input  fsg_pkg::t_cell    i_ram_rdata
);
    import fsg_pkg::*;

    t_state                 r_state, n_state, step_next;
    logic [ADDR_BITS-1:0]   r_cnt;
    logic                   r_from_cmd;
    logic [X_BITS-1:0]      r_x;
    logic [Y_BITS-1:0]      r_y;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [ADDR_BITS-1:0]   r_dest;
    logic                   r_res_occ;
    logic [PAY_IO_BITS-1:0] r_res_pay;
    logic                   r_res_rng;
    logic                   r_out_valid;
    logic                   r_out_occ;
    logic [PAY_IO_BITS-1:0] r_out_pay;
    logic                   r_out_rng;

    logic                   acc, in_grid, out_free, cnt_last;
    logic                   has_r, has_l, adv, in_step;
    t_cmd                   in_cmd;
    logic [X_BITS-1:0]      x_rt, x_lf, in_x;
    logic [Y_BITS-1:0]      y_dn, in_y;
    logic [ADDR_BITS-1:0]   a_here, a_below, a_br, a_r, a_bl, a_l;
    logic                   rd_occ;

    assign acc      = i_req.valid && i_req.ready;
    assign in_cmd   = t_cmd'(i_req.cmd);
    assign in_x     = X_BITS'(i_req.cell_x);
    assign in_y     = Y_BITS'(i_req.cell_y);
    assign in_grid  = (CFG_BITS'(i_req.cell_x) < i_grid.w)
                   && (CFG_BITS'(i_req.cell_y) < i_grid.h);
    assign out_free = !r_out_valid || o_res.ready;
    assign cnt_last = r_cnt == ADDR_BITS'(CELL_COUNT - 1);
    assign rd_occ   = i_ram_rdata.occ;

    assign x_rt  = r_x + 1'b1;
    assign x_lf  = r_x - 1'b1;
    assign y_dn  = r_y + 1'b1;
    assign has_r = (CFG_BITS'(r_x) + 1'b1) < i_grid.w;
    assign has_l = r_x != '0;

    assign a_here  = slot(r_x, r_y);
    assign a_below = slot(r_x, y_dn);
    assign a_br    = slot(x_rt, y_dn);
    assign a_r     = slot(x_rt, r_y);
    assign a_bl    = slot(x_lf, y_dn);
    assign a_l     = slot(x_lf, r_y);

    assign step_next = (!has_r && r_y == '0) ? ST_PUSH : ST_S_HERE;

    assign in_step = r_state == ST_S_HERE || r_state == ST_S_HC || r_state == ST_S_B
                  || r_state == ST_S_BR || r_state == ST_S_R || r_state == ST_S_BL
                  || r_state == ST_S_L || r_state == ST_S_MOVE || r_state == ST_S_VAC;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (cnt_last) begin
                    n_state = r_from_cmd ? ST_PUSH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    unique case (in_cmd)
                        CMD_WRITE: n_state = ST_PUSH;
                        CMD_READ:  n_state = in_grid ? ST_RD : ST_PUSH;
                        CMD_STEP:  n_state = ST_S_HERE;
                        CMD_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD:     n_state = ST_PUSH;
            ST_PUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_S_HERE: n_state = ST_S_HC;
            ST_S_HC:   n_state = rd_occ ? ST_S_B : step_next;
            ST_S_B: begin
                priority if (!rd_occ) n_state = ST_S_MOVE;
                else if (has_r)       n_state = ST_S_BR;
                else if (has_l)       n_state = ST_S_BL;
                else                  n_state = step_next;
            end
            ST_S_BR: begin
                priority if (!rd_occ) n_state = ST_S_R;
                else if (has_l)       n_state = ST_S_BL;
                else                  n_state = step_next;
            end
            ST_S_R: begin
                priority if (!rd_occ) n_state = ST_S_MOVE;
                else if (has_l)       n_state = ST_S_BL;
                else                  n_state = step_next;
            end
            ST_S_BL:   n_state = !rd_occ ? ST_S_L : step_next;
            ST_S_L:    n_state = !rd_occ ? ST_S_MOVE : step_next;
            ST_S_MOVE: n_state = ST_S_VAC;
            ST_S_VAC:  n_state = step_next;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ram_req       = '0;
        o_ram_req.addr  = a_here;
        adv             = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_ram_req.we   = 1'b1;
                o_ram_req.addr = r_cnt;
            end
            ST_IDLE: begin
                o_ram_req.addr = slot(in_x, in_y);
                if (acc && in_cmd == CMD_WRITE && in_grid) begin
                    o_ram_req.we        = 1'b1;
                    o_ram_req.wdata.occ = i_req.occupied_in;
                    o_ram_req.wdata.pay = PAYLOAD_BITS'(i_req.payload_in);
                end
            end
            ST_RD, ST_PUSH: begin
            end
            ST_S_HERE: o_ram_req.addr = a_here;
            ST_S_HC: begin
                o_ram_req.addr = a_below;
                adv            = !rd_occ;
            end
            ST_S_B: begin
                o_ram_req.addr = has_r ? a_br : a_bl;
                adv            = rd_occ && !has_r && !has_l;
            end
            ST_S_BR: begin
                o_ram_req.addr = !rd_occ ? a_r : a_bl;
                adv            = rd_occ && !has_l;
            end
            ST_S_R: begin
                o_ram_req.addr = a_bl;
                adv            = rd_occ && !has_l;
            end
            ST_S_BL: begin
                o_ram_req.addr = a_l;
                adv            = rd_occ;
            end
            ST_S_L: begin
                adv = rd_occ;
            end
            ST_S_MOVE: begin
                o_ram_req.we        = 1'b1;
                o_ram_req.addr      = r_dest;
                o_ram_req.wdata.occ = 1'b1;
                o_ram_req.wdata.pay = r_pay;
            end
            ST_S_VAC: begin
                o_ram_req.we   = 1'b1;
                o_ram_req.addr = a_here;
                adv            = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_from_cmd  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (acc && in_cmd == CMD_CLEAR) begin
                r_cnt      <= '0;
                r_from_cmd <= 1'b1;
            end
            if (r_state == ST_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res_occ <= 1'b0;
            r_res_pay <= '0;
            r_res_rng <= (in_cmd == CMD_WRITE || in_cmd == CMD_READ) && in_grid;
            r_x       <= '0;
            r_y       <= Y_BITS'(i_grid.h - 2'd2);
        end else if (adv) begin
            if (has_r) begin
                r_x <= x_rt;
            end else begin
                r_x <= '0;
                r_y <= r_y - 1'b1;
            end
        end
        if (r_state == ST_RD) begin
            r_res_occ <= i_ram_rdata.occ;
            r_res_pay <= PAY_IO_BITS'(i_ram_rdata.pay);
        end
        if (r_state == ST_S_HC) begin
            r_pay <= i_ram_rdata.pay;
        end
        if (!rd_occ) begin
            if (r_state == ST_S_B) r_dest <= a_below;
            if (r_state == ST_S_R) r_dest <= a_br;
            if (r_state == ST_S_L) r_dest <= a_bl;
        end
        if (r_state == ST_PUSH && out_free) begin
            r_out_occ <= r_res_occ;
            r_out_pay <= r_res_pay;
            r_out_rng <= r_res_rng;
        end
    end

    assign i_req.ready        = r_state == ST_IDLE;
    assign o_res.valid        = r_out_valid;
    assign o_res.occupied_out = r_out_occ;
    assign o_res.payload_out  = r_out_pay;
    assign o_res.in_range     = r_out_rng;

    a_col_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_step |-> CFG_BITS'(r_x) < i_grid.w)
        else $error("step column outside grid");

    a_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_step |-> (CFG_BITS'(r_y) + 2'd2) <= i_grid.h)
        else $error("step row outside grid");

    a_move_vacate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_S_MOVE |=> r_state == ST_S_VAC && o_ram_req.we
                                 && !o_ram_req.wdata.occ)
        else $error("move not followed by vacate");

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR && !cnt_last |=> r_state == ST_CLEAR
                                 && r_cnt == ADDR_BITS'($past(r_cnt) + 1'b1))
        else $error("clear sweep broken");

    a_push_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PUSH || r_state == ST_RD |-> !o_ram_req.we)
        else $error("store written while result pending");

endmodule

FILE: hdl/falling_sand_grid_step.sv
`timescale 1ns / 1ps
// Write: result pushed once the request is taken; read: after the store read; clear: after the clearing pass.
// Step: sweeps the width x (height-1) region cell by cell, bound by the
// single-port cell store (one read or one write a cycle), then pushes its result.
// One request in work at a time; the next is taken while a result waits.
// Reset: registers to 64 x 64, then a clearing pass over all 4096 cells with no request taken.
// Configuration writes are always taken.

module falling_sand_grid_step (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsg_cfg_if.sink   i_cfg,
    fsg_in_if.sink    i_req,
    fsg_out_if.source o_res
);
    import fsg_pkg::*;

    logic [CFG_BITS-1:0] r_grid_w;
    logic [CFG_BITS-1:0] r_grid_h;
    t_grid               grid;
    t_ram_req            ram_req;
    t_cell               ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= CFG_WIDTH_RESET;
            r_grid_h <= CFG_HEIGHT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == REG_GRID_WIDTH)  r_grid_w <= i_cfg.data;
            if (i_cfg.index == REG_GRID_HEIGHT) r_grid_h <= i_cfg.data;
        end
    end

    always_comb begin
        priority if (r_grid_w == '0)                    grid.w = CFG_BITS'(1);
        else if (r_grid_w > CFG_BITS'(MAX_WIDTH))       grid.w = CFG_BITS'(MAX_WIDTH);
        else                                            grid.w = r_grid_w;
        priority if (r_grid_h < CFG_BITS'(2))           grid.h = CFG_BITS'(2);
        else if (r_grid_h > CFG_BITS'(MAX_HEIGHT))      grid.h = CFG_BITS'(MAX_HEIGHT);
        else                                            grid.h = r_grid_h;
    end

    assign i_cfg.ready = 1'b1;

    fsg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid      (grid),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    fsg_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule
